@@ rtl/core/bipq_pkg.sv @@
`timescale 1ns / 1ps

package bipq_pkg;

    localparam int CMD_W = 3;
    localparam int IDX_W = 8;
    localparam int CFG_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT     = 3'd0,
        CMD_SUBMIT   = 3'd1,
        CMD_TAKE     = 3'd2,
        CMD_RETURN   = 3'd3,
        CMD_GET_FREE = 3'd4
    } cmd_t;

    localparam logic [0:0] REG_SLOT_LIMIT = 1'd0;
    localparam logic [0:0] REG_POOL_COUNT = 1'd1;

    localparam logic [CFG_W-1:0] SLOT_LIMIT_RESET = 5'd8;
    localparam logic [CFG_W-1:0] POOL_COUNT_RESET = 5'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] ring_index;
    } req_t;

    typedef struct packed {
        logic             success;
        logic [IDX_W-1:0] index_out;
    } rsp_t;

    // outcome of one command, as seen by the result stage
    typedef struct packed {
        logic success;
        logic pop;
        logic from_free;
    } step_t;

endpackage

@@ rtl/core/bipq_stream_if.sv @@
`timescale 1ns / 1ps

interface bipq_stream_if #(parameter type payload_t = logic [0:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/buffer_index_pool_queues_core.sv @@
`timescale 1ns / 1ps

// a result beat is offered in the cycle after its command beat is accepted
// throughput: one command per cycle unless preloading or the result slot is held;
// pops read the queue memory in the accept cycle; init blocks commands while it
// preloads min(pool_count-1, size-1) entries into the free queue, one per cycle
// reset: head/tail pointers cleared, slot limit 8, pool count 4; queue memories are
// not cleared and hold unknown data until written

module buffer_index_pool_queues_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [bipq_pkg::CFG_W-1:0] cfg_wdata,
    bipq_stream_if.sink                request,
    bipq_stream_if.source              response
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    // configuration registers
    logic [bipq_pkg::CFG_W-1:0] slot_limit_reg;
    logic [bipq_pkg::CFG_W-1:0] pool_count_reg;

    // result stage
    logic            rsp_valid_reg;
    bipq_pkg::step_t rsp_step_reg;

    logic            in_accept;
    logic            busy;
    bipq_pkg::step_t step;

    // memory ports
    logic                      submit_we;
    logic [PW-1:0]             submit_waddr;
    logic                      submit_re;
    logic [PW-1:0]             submit_raddr;
    logic [bipq_pkg::IDX_W-1:0] submit_rdata;
    logic                      free_we;
    logic [PW-1:0]             free_waddr;
    logic [bipq_pkg::IDX_W-1:0] free_wdata;
    logic                      free_re;
    logic [PW-1:0]             free_raddr;
    logic [bipq_pkg::IDX_W-1:0] free_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= bipq_pkg::SLOT_LIMIT_RESET;
            pool_count_reg <= bipq_pkg::POOL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bipq_pkg::REG_SLOT_LIMIT:
                begin
                    slot_limit_reg <= cfg_wdata;
                end
                bipq_pkg::REG_POOL_COUNT:
                begin
                    pool_count_reg <= cfg_wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    // take a new beat when not preloading and the result slot frees up this cycle
    assign request.ready = !busy && (!rsp_valid_reg || response.ready);
    assign in_accept     = request.valid && request.ready;

    bipq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .command      (request.payload.command),
        .ring_index   (request.payload.ring_index),
        .slot_limit   (slot_limit_reg),
        .pool_count   (pool_count_reg),
        .step         (step),
        .busy         (busy),
        .submit_we    (submit_we),
        .submit_waddr (submit_waddr),
        .submit_re    (submit_re),
        .submit_raddr (submit_raddr),
        .free_we      (free_we),
        .free_waddr   (free_waddr),
        .free_wdata   (free_wdata),
        .free_re      (free_re),
        .free_raddr   (free_raddr)
    );

    // submit queue store
    bipq_ram #(
        .WIDTH (bipq_pkg::IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_submit_ram (
        .clk   (clk),
        .we    (submit_we),
        .waddr (submit_waddr),
        .wdata (request.payload.ring_index),
        .re    (submit_re),
        .raddr (submit_raddr),
        .rdata (submit_rdata)
    );

    // free queue store, also written by the init preload
    bipq_ram #(
        .WIDTH (bipq_pkg::IDX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // step info only; popped data sits in the memory read register, which
    // holds until the next pop from the same queue is accepted
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rsp_step_reg <= step;
        end
    end

    assign response.valid             = rsp_valid_reg;
    assign response.payload.success   = rsp_step_reg.success;
    assign response.payload.index_out =
        (rsp_step_reg.success && rsp_step_reg.pop)
            ? (rsp_step_reg.from_free ? free_rdata : submit_rdata)
            : '0;

endmodule

@@ rtl/core/bipq_ram.sv @@
`timescale 1ns / 1ps

module bipq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bipq_ctrl.sv @@
`timescale 1ns / 1ps

module bipq_ctrl #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [bipq_pkg::CMD_W-1:0]          command,
    input  logic [bipq_pkg::IDX_W-1:0]          ring_index,
    input  logic [bipq_pkg::CFG_W-1:0]          slot_limit,
    input  logic [bipq_pkg::CFG_W-1:0]          pool_count,
    output bipq_pkg::step_t                     step,
    output logic                                busy,
    output logic                                submit_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      submit_waddr,
    output logic                                submit_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      submit_raddr,
    output logic                                free_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      free_waddr,
    output logic [bipq_pkg::IDX_W-1:0]          free_wdata,
    output logic                                free_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]      free_raddr
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int SW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    state_t          state_reg;
    logic [PW-1:0]   sub_head_reg;
    logic [PW-1:0]   sub_tail_reg;
    logic [PW-1:0]   free_head_reg;
    logic [PW-1:0]   free_tail_reg;
    logic [PW-1:0]   fill_cnt_reg;
    logic [PW-1:0]   fill_last_reg;

    logic [SW-1:0]   eff_size;
    logic [PW-1:0]   sub_tail_next;
    logic [PW-1:0]   sub_head_next;
    logic [PW-1:0]   free_tail_next;
    logic [PW-1:0]   free_head_next;
    logic            sub_full;
    logic            sub_empty;
    logic            free_full;
    logic            free_empty;
    logic [bipq_pkg::CFG_W-1:0] rc_m1;
    logic [PW-1:0]   fill_n;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [SW-1:0] sz);
        logic [SW-1:0] n;
        n = SW'(p) + SW'(1);
        return (n >= sz) ? '0 : n[PW-1:0];
    endfunction

    // size clamped to 2 .. depth
    always_comb
    begin
        if (32'(slot_limit) > QUEUE_DEPTH)
        begin
            eff_size = SW'(QUEUE_DEPTH);
        end
        else if (slot_limit < 5'd2)
        begin
            eff_size = SW'(2);
        end
        else
        begin
            eff_size = SW'(slot_limit);
        end
    end

    assign sub_tail_next  = advance(sub_tail_reg, eff_size);
    assign sub_head_next  = advance(sub_head_reg, eff_size);
    assign free_tail_next = advance(free_tail_reg, eff_size);
    assign free_head_next = advance(free_head_reg, eff_size);
    assign sub_full       = (sub_tail_next == sub_head_reg);
    assign sub_empty      = (sub_head_reg == sub_tail_reg);
    assign free_full      = (free_tail_next == free_head_reg);
    assign free_empty     = (free_head_reg == free_tail_reg);

    // preload count: min(pool_count - 1, size - 1)
    assign rc_m1  = pool_count - 5'd1;
    assign fill_n = (32'(rc_m1) > (32'(eff_size) - 32'd1)) ? PW'(eff_size - SW'(1))
                                                         : PW'(rc_m1);

    always_comb
    begin
        step = '0;
        case (command)
            bipq_pkg::CMD_INIT:
            begin
                step.success = (pool_count != '0);
            end
            bipq_pkg::CMD_SUBMIT:
            begin
                step.success = !sub_full;
            end
            bipq_pkg::CMD_TAKE:
            begin
                step.success = !sub_empty;
                step.pop     = 1'b1;
            end
            bipq_pkg::CMD_RETURN:
            begin
                step.success = !free_full;
            end
            bipq_pkg::CMD_GET_FREE:
            begin
                step.success   = !free_empty;
                step.pop       = 1'b1;
                step.from_free = 1'b1;
            end
            default:
            begin
                step = '0;
            end
        endcase
    end

    assign busy         = (state_reg == ST_FILL);
    assign submit_we    = accept && (command == bipq_pkg::CMD_SUBMIT) && !sub_full;
    assign submit_waddr = sub_tail_reg;
    assign submit_re    = accept && (command == bipq_pkg::CMD_TAKE);
    assign submit_raddr = sub_head_reg;
    assign free_we      = busy || (accept && (command == bipq_pkg::CMD_RETURN) && !free_full);
    assign free_waddr   = busy ? fill_cnt_reg : free_tail_reg;
    assign free_wdata   = busy ? (bipq_pkg::IDX_W'(fill_cnt_reg) + bipq_pkg::IDX_W'(1))
                               : ring_index;
    assign free_re      = accept && (command == bipq_pkg::CMD_GET_FREE);
    assign free_raddr   = free_head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sub_head_reg  <= '0;
            sub_tail_reg  <= '0;
            free_head_reg <= '0;
            free_tail_reg <= '0;
            fill_cnt_reg  <= '0;
            fill_last_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (command)
                            bipq_pkg::CMD_INIT:
                            begin
                                if (pool_count != '0)
                                begin
                                    free_tail_reg <= fill_n;
                                    if (fill_n != '0)
                                    begin
                                        state_reg     <= ST_FILL;
                                        fill_cnt_reg  <= '0;
                                        fill_last_reg <= fill_n;
                                    end
                                end
                            end
                            bipq_pkg::CMD_SUBMIT:
                            begin
                                if (!sub_full)
                                begin
                                    sub_tail_reg <= sub_tail_next;
                                end
                            end
                            bipq_pkg::CMD_TAKE:
                            begin
                                if (!sub_empty)
                                begin
                                    sub_head_reg <= sub_head_next;
                                end
                            end
                            bipq_pkg::CMD_RETURN:
                            begin
                                if (!free_full)
                                begin
                                    free_tail_reg <= free_tail_next;
                                end
                            end
                            bipq_pkg::CMD_GET_FREE:
                            begin
                                if (!free_empty)
                                begin
                                    free_head_reg <= free_head_next;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    fill_cnt_reg <= fill_cnt_reg + PW'(1);
                    if (fill_cnt_reg == (fill_last_reg - PW'(1)))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // a successful take always moves the head
    a_take_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == bipq_pkg::CMD_TAKE) && !sub_empty
        |=> sub_head_reg != $past(sub_head_reg))
        else $error("take did not advance submit head");

    // a refused return leaves the free tail alone
    a_full_return_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (command == bipq_pkg::CMD_RETURN) && free_full
        |=> $stable(free_tail_reg))
        else $error("refused return moved free tail");

    // the preload stays inside the count latched at init
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fill_cnt_reg < fill_last_reg))
        else $error("preload address past its count");

    // preload starts only from an accepted init
    a_fill_from_init: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(accept && (command == bipq_pkg::CMD_INIT)))
        else $error("preload started without init");
`endif

endmodule
